// File: design/bvs_pkg.sv
`default_nettype none

package bvs_pkg;

    localparam int DATA_W    = 16;
    localparam int OP_W      = 3;
    localparam int IDX_W     = 8;
    localparam int BANK_W    = 4;
    localparam int CNT_W     = 8;
    localparam int IDX_SPAN  = 1 << IDX_W;
    localparam int BANK_SPAN = 1 << BANK_W;

    // Opcodes as they arrive on the request channel. Codes 6 and 7 are undefined.
    typedef enum logic [OP_W-1:0] {
        OP_READ             = 3'd0,
        OP_WRITE            = 3'd1,
        OP_SELECT_BANK      = 3'd2,
        OP_SET_AUX          = 3'd3,
        OP_COPY_TO_GLOBAL   = 3'd4,
        OP_COPY_FROM_GLOBAL = 3'd5
    } bvs_op_t;

    // Work classes that the front hands to the back.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_COPY  = 2'd3
    } bvs_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR   = 3'd0,
        ST_IDLE    = 3'd1,
        ST_READ    = 3'd2,
        ST_COPY_RD = 3'd3,
        ST_COPY_WR = 3'd4
    } bvs_state_t;

    typedef struct packed {
        bvs_kind_t                kind;
        logic                     src_task;
        logic                     dst_task;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] wdata;
        logic                     prev_aux;
        logic                     done;
    } bvs_cmd_t;

endpackage

`default_nettype wire

// File: design/bvs_ram.sv
`default_nettype none

module bvs_ram
    #(
        parameter int WIDTH = 16,
        parameter int DEPTH = 256
    )
    (
        input  wire logic                     clk,
        input  wire logic                     we,
        input  wire logic [$clog2(DEPTH)-1:0] waddr,
        input  wire logic [WIDTH-1:0]         wdata,
        input  wire logic                     re,
        input  wire logic [$clog2(DEPTH)-1:0] raddr,
        output logic      [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/bvs_front.sv
`default_nettype none

module bvs_front
    import bvs_pkg::*;
    #(
        parameter int GLOBAL_VARS = 256,
        parameter int TASKS       = 16,
        parameter int BANK_SIZE   = 32,
        localparam int TASK_DEPTH = TASKS * BANK_SIZE,
        localparam int GW         = $clog2(GLOBAL_VARS),
        localparam int TW         = $clog2(TASK_DEPTH),
        localparam int AW         = (GW > TW) ? GW : TW
    )
    (
        input  wire logic                     clk,
        input  wire logic                     rst_n,
        input  wire logic                     req_valid,
        output logic                          req_stall,
        input  wire logic [OP_W-1:0]          opcode,
        input  wire logic [IDX_W-1:0]         var_index,
        input  wire logic signed [DATA_W-1:0] write_value,
        input  wire logic [BANK_W-1:0]        bank_number,
        input  wire logic                     aux_mode,
        input  wire logic [IDX_W-1:0]         dest_start,
        input  wire logic [IDX_W-1:0]         source_start,
        input  wire logic [CNT_W-1:0]         copy_count,
        input  wire logic                     clearing,
        output logic                          head_valid,
        output bvs_cmd_t                      head_cmd,
        output logic [AW-1:0]                 head_src_addr,
        output logic [AW-1:0]                 head_dst_addr,
        input  wire logic                     pop
    );

    localparam int Q_DEPTH = 2;
    localparam logic [TW:0] TD_EXT = (TW+1)'(TASK_DEPTH);

    // Index reduction tables, filled at elaboration.
    logic [GW-1:0] gmod_tab [IDX_SPAN];
    logic [TW-1:0] tmod_tab [IDX_SPAN];
    logic [TW-1:0] base_tab [BANK_SPAN];

    for (genvar v = 0; v < IDX_SPAN; v++)
    begin : g_idx
        localparam int GM = v % GLOBAL_VARS;
        localparam int TM = v % TASK_DEPTH;
        assign gmod_tab[v] = GW'(GM);
        assign tmod_tab[v] = TW'(TM);
    end

    for (genvar b = 0; b < BANK_SPAN; b++)
    begin : g_bank
        localparam int BB = (b * BANK_SIZE) % TASK_DEPTH;
        assign base_tab[b] = TW'(BB);
    end

    logic [TW-1:0] bank_base_reg;
    logic [TW-1:0] bank_base_next;
    logic          aux_reg;
    logic          aux_next;

    bvs_cmd_t      q_cmd_reg [Q_DEPTH];
    logic [AW-1:0] q_src_reg [Q_DEPTH];
    logic [AW-1:0] q_dst_reg [Q_DEPTH];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    bvs_op_t       op;
    logic [IDX_W-1:0] view_idx;
    logic [IDX_W-1:0] glob_idx;
    logic [TW:0]   t_sum;
    logic [TW-1:0] t_addr;
    logic [AW-1:0] view_addr;
    logic [AW-1:0] glob_addr;
    bvs_cmd_t      cmd;
    logic [AW-1:0] src_addr;
    logic [AW-1:0] dst_addr;
    logic          accept;

    assign req_stall = clearing || (count_reg == 2'(Q_DEPTH));
    assign accept    = req_valid && !req_stall;
    assign op        = bvs_op_t'(opcode);

    // The task view address is the bank base plus the reduced index, wrapped once.
    always_comb
    begin
        view_idx = (op == OP_COPY_TO_GLOBAL)   ? source_start :
                   (op == OP_COPY_FROM_GLOBAL) ? dest_start   : var_index;
        glob_idx = (op == OP_COPY_TO_GLOBAL) ? dest_start : source_start;
        t_sum    = {1'b0, bank_base_reg} + {1'b0, tmod_tab[view_idx]};
        t_addr   = (t_sum >= TD_EXT) ? TW'(t_sum - TD_EXT) : t_sum[TW-1:0];
        view_addr = aux_reg ? AW'(t_addr) : AW'(gmod_tab[view_idx]);
        glob_addr = AW'(gmod_tab[glob_idx]);
    end

    always_comb
    begin
        cmd            = '0;
        cmd.kind       = KIND_NONE;
        cmd.done       = 1'b1;
        cmd.count      = copy_count;
        cmd.wdata      = write_value;
        src_addr       = view_addr;
        dst_addr       = view_addr;
        bank_base_next = bank_base_reg;
        aux_next       = aux_reg;
        case (op)
            OP_READ:
            begin
                cmd.kind     = KIND_READ;
                cmd.src_task = aux_reg;
            end
            OP_WRITE:
            begin
                cmd.kind     = KIND_WRITE;
                cmd.dst_task = aux_reg;
            end
            OP_SELECT_BANK:
            begin
                bank_base_next = base_tab[bank_number];
            end
            OP_SET_AUX:
            begin
                cmd.prev_aux = aux_reg;
                aux_next     = aux_mode;
            end
            OP_COPY_TO_GLOBAL:
            begin
                cmd.kind     = KIND_COPY;
                cmd.src_task = aux_reg;
                dst_addr     = glob_addr;
            end
            OP_COPY_FROM_GLOBAL:
            begin
                cmd.kind     = KIND_COPY;
                cmd.dst_task = aux_reg;
                src_addr     = glob_addr;
            end
            default:
            begin
                cmd.done = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case ({accept, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_base_reg <= '0;
            aux_reg       <= 1'b0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                bank_base_reg <= bank_base_next;
                aux_reg       <= aux_next;
                wr_ptr_reg    <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_cmd_reg[wr_ptr_reg] <= cmd;
            q_src_reg[wr_ptr_reg] <= src_addr;
            q_dst_reg[wr_ptr_reg] <= dst_addr;
        end
    end

    assign head_valid    = (count_reg != 2'd0);
    assign head_cmd      = q_cmd_reg[rd_ptr_reg];
    assign head_src_addr = q_src_reg[rd_ptr_reg];
    assign head_dst_addr = q_dst_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: design/bvs_back.sv
`default_nettype none

module bvs_back
    import bvs_pkg::*;
    #(
        parameter int GLOBAL_VARS = 256,
        parameter int TASKS       = 16,
        parameter int BANK_SIZE   = 32,
        localparam int TASK_DEPTH = TASKS * BANK_SIZE,
        localparam int GW         = $clog2(GLOBAL_VARS),
        localparam int TW         = $clog2(TASK_DEPTH),
        localparam int AW         = (GW > TW) ? GW : TW
    )
    (
        input  wire logic                     clk,
        input  wire logic                     rst_n,
        input  wire logic                     head_valid,
        input  wire bvs_cmd_t                 head_cmd,
        input  wire logic [AW-1:0]            head_src_addr,
        input  wire logic [AW-1:0]            head_dst_addr,
        output logic                          pop,
        output logic                          clearing,
        output logic                          rsp_valid,
        input  wire logic                     rsp_stall,
        output logic signed [DATA_W-1:0]      read_data,
        output logic                          previous_aux,
        output logic                          done_res
    );

    localparam int MAX_DEPTH = (GLOBAL_VARS > TASK_DEPTH) ? GLOBAL_VARS : TASK_DEPTH;
    localparam int CLW       = $clog2(MAX_DEPTH);
    localparam logic [CLW-1:0] CLR_LAST = CLW'(MAX_DEPTH - 1);
    localparam logic [CLW:0]   G_LIM    = (CLW+1)'(GLOBAL_VARS);
    localparam logic [CLW:0]   T_LIM    = (CLW+1)'(TASK_DEPTH);
    localparam logic [AW-1:0]  G_LAST   = AW'(GLOBAL_VARS - 1);
    localparam logic [AW-1:0]  T_LAST   = AW'(TASK_DEPTH - 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p, input logic in_task);
        logic [AW-1:0] last;
        last = in_task ? T_LAST : G_LAST;
        return (p == last) ? '0 : p + AW'(1);
    endfunction

    bvs_state_t        state_reg;
    bvs_state_t        state_next;
    logic [CLW-1:0]    clr_reg;
    logic [CLW-1:0]    clr_next;
    logic [AW-1:0]     src_reg;
    logic [AW-1:0]     src_next;
    logic [AW-1:0]     dst_reg;
    logic [AW-1:0]     dst_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] read_data_reg;
    logic [DATA_W-1:0] read_data_next;
    logic              prev_reg;
    logic              prev_next;
    logic              done_reg;
    logic              done_next;

    logic              out_free;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] g_rdata;
    logic [DATA_W-1:0] t_rdata;
    logic [DATA_W-1:0] rd_word;
    logic              g_we;
    logic              t_we;
    logic [GW-1:0]     g_waddr;
    logic [TW-1:0]     t_waddr;
    logic [DATA_W-1:0] ram_wdata;

    assign clearing = (state_reg == ST_CLEAR);
    assign out_free = !out_valid_reg || !rsp_stall;
    assign rd_word  = head_cmd.src_task ? t_rdata : g_rdata;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        read_data_next = read_data_reg;
        prev_next      = prev_reg;
        done_next      = done_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head_src_addr;
        wr_en          = 1'b0;
        wr_addr        = head_dst_addr;
        wr_data        = head_cmd.wdata;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + CLW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    case (head_cmd.kind)
                        KIND_READ:
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_READ;
                        end
                        KIND_COPY:
                        begin
                            rd_en      = 1'b1;
                            src_next   = ptr_inc(head_src_addr, head_cmd.src_task);
                            dst_next   = head_dst_addr;
                            cnt_next   = head_cmd.count;
                            state_next = ST_COPY_WR;
                        end
                        KIND_WRITE:
                        begin
                            if (out_free)
                            begin
                                wr_en          = 1'b1;
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                read_data_next = '0;
                                prev_next      = 1'b0;
                                done_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                read_data_next = '0;
                                prev_next      = head_cmd.prev_aux;
                                done_next      = head_cmd.done;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    pop            = 1'b1;
                    out_valid_next = 1'b1;
                    read_data_next = rd_word;
                    prev_next      = 1'b0;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_COPY_WR:
            begin
                wr_addr = dst_reg;
                wr_data = rd_word;
                if (cnt_reg != '0)
                begin
                    wr_en      = 1'b1;
                    dst_next   = ptr_inc(dst_reg, head_cmd.dst_task);
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_COPY_RD;
                end
                else if (out_free)
                begin
                    // Last element: it goes out with the result.
                    wr_en          = 1'b1;
                    pop            = 1'b1;
                    out_valid_next = 1'b1;
                    read_data_next = '0;
                    prev_next      = 1'b0;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_COPY_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = src_reg;
                src_next   = ptr_inc(src_reg, head_cmd.src_task);
                state_next = ST_COPY_WR;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The clearing pass owns both write ports until it ends.
    always_comb
    begin
        if (clearing)
        begin
            g_we      = ({1'b0, clr_reg} < G_LIM);
            t_we      = ({1'b0, clr_reg} < T_LIM);
            g_waddr   = GW'(clr_reg);
            t_waddr   = TW'(clr_reg);
            ram_wdata = '0;
        end
        else
        begin
            g_we      = wr_en && !head_cmd.dst_task;
            t_we      = wr_en && head_cmd.dst_task;
            g_waddr   = wr_addr[GW-1:0];
            t_waddr   = wr_addr[TW-1:0];
            ram_wdata = wr_data;
        end
    end

    bvs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (GLOBAL_VARS)
    ) u_global_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr[GW-1:0]),
        .rdata (g_rdata)
    );

    bvs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TASK_DEPTH)
    ) u_task_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr[TW-1:0]),
        .rdata (t_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        cnt_reg       <= cnt_next;
        read_data_reg <= read_data_next;
        prev_reg      <= prev_next;
        done_reg      <= done_next;
    end

    assign rsp_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign previous_aux = prev_reg;
    assign done_res     = done_reg;

endmodule

`default_nettype wire

// File: design/banked_variable_store.sv
// Variable store of a script machine: a global bank and a flat task store
// split into banks, with single reads and writes and block copies.
// Request channel (req_valid / req_stall) carries one operation per beat:
// opcode, var_index, write_value, bank_number, aux_mode, dest_start,
// source_start and copy_count. Response channel (rsp_valid / rsp_stall)
// returns exactly one beat per request, in order: read_data, previous_aux
// and done_res.
// A read addresses the memory from idle and answers from the read state,
// and a block copy moves copy_count + 1 elements one at a time, reading
// each through the single read port of its memory and then writing it.
// Writes and register operations sustain one beat per clock while
// rsp_stall stays low; a read holds the sequencer until its word is
// returned. A two-entry command queue sits between decode and
// the memory sequencer, so requests keep being taken while one works.
// After reset both memories are swept to zero, one address per clock,
// over max(GLOBAL_VARS, TASKS * BANK_SIZE) addresses (512 at the defaults);
// req_stall stays high during the sweep. When rsp_stall is high the
// response register holds its beat and the sequencer waits at its last
// step; the queue then fills and req_stall rises.
`default_nettype none

module banked_variable_store
    import bvs_pkg::*;
    #(
        parameter int GLOBAL_VARS = 256,
        parameter int TASKS       = 16,
        parameter int BANK_SIZE   = 32
    )
    (
        input  wire logic                     clk,
        input  wire logic                     rst_n,
        input  wire logic                     req_valid,
        output logic                          req_stall,
        input  wire logic [OP_W-1:0]          opcode,
        input  wire logic [IDX_W-1:0]         var_index,
        input  wire logic signed [DATA_W-1:0] write_value,
        input  wire logic [BANK_W-1:0]        bank_number,
        input  wire logic                     aux_mode,
        input  wire logic [IDX_W-1:0]         dest_start,
        input  wire logic [IDX_W-1:0]         source_start,
        input  wire logic [CNT_W-1:0]         copy_count,
        output logic                          rsp_valid,
        input  wire logic                     rsp_stall,
        output logic signed [DATA_W-1:0]      read_data,
        output logic                          previous_aux,
        output logic                          done_res
    );

    localparam int TASK_DEPTH = TASKS * BANK_SIZE;
    localparam int GW         = $clog2(GLOBAL_VARS);
    localparam int TW         = $clog2(TASK_DEPTH);
    localparam int AW         = (GW > TW) ? GW : TW;

    // Queue head as seen by the sequencer. Addresses are already reduced
    // into the target memory, so the back end only steps and wraps them.
    logic          head_valid;
    bvs_cmd_t      head_cmd;
    logic [AW-1:0] head_src_addr;
    logic [AW-1:0] head_dst_addr;
    logic          pop;
    logic          clearing;

    // Decode keeps the bank base and aux flag, since those only change
    // in request order and every later address depends on them.
    bvs_front #(
        .GLOBAL_VARS (GLOBAL_VARS),
        .TASKS       (TASKS),
        .BANK_SIZE   (BANK_SIZE)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .opcode        (opcode),
        .var_index     (var_index),
        .write_value   (write_value),
        .bank_number   (bank_number),
        .aux_mode      (aux_mode),
        .dest_start    (dest_start),
        .source_start  (source_start),
        .copy_count    (copy_count),
        .clearing      (clearing),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .head_src_addr (head_src_addr),
        .head_dst_addr (head_dst_addr),
        .pop           (pop)
    );

    // The sequencer owns both memories and the response register. A copy
    // reads and then writes each element, so overlapping ranges see the
    // elements already moved, in rising index order.
    bvs_back #(
        .GLOBAL_VARS (GLOBAL_VARS),
        .TASKS       (TASKS),
        .BANK_SIZE   (BANK_SIZE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .head_src_addr (head_src_addr),
        .head_dst_addr (head_dst_addr),
        .pop           (pop),
        .clearing      (clearing),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .read_data     (read_data),
        .previous_aux  (previous_aux),
        .done_res      (done_res)
    );

endmodule

`default_nettype wire

// File: design/bvs_checker.sv
`default_nettype none

module bvs_checker
    import bvs_pkg::*;
    (
        input wire logic                     clk,
        input wire logic                     rst_n,
        input wire logic                     req_valid,
        input wire logic                     req_stall,
        input wire logic                     rsp_valid,
        input wire logic                     rsp_stall,
        input wire logic signed [DATA_W-1:0] read_data,
        input wire logic                     previous_aux,
        input wire logic                     done_res
    );

    // A held response beat keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data)
            && $stable(previous_aux) && $stable(done_res))
        else $error("response changed while stalled");

    // The zeroing sweep blocks requests right after reset.
    a_sweep_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> req_stall && !rsp_valid)
        else $error("request taken or response shown during the memory sweep");

    // Only a set aux mode returns a flag, and it never carries read data.
    a_prev_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && previous_aux |-> done_res && (read_data == 16'sd0))
        else $error("previous aux flag on a wrong response");

    // Undefined opcodes give an all-zero response.
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !done_res |-> (read_data == 16'sd0) && !previous_aux)
        else $error("undefined opcode response not zero");

    // Handshake outputs and a shown response beat are always fully defined.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({req_stall, rsp_valid})
            && (!rsp_valid || !$isunknown({read_data, previous_aux, done_res})))
        else $error("unknown value on a handshake or response port");

endmodule

bind banked_variable_store bvs_checker u_bvs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .read_data    (read_data),
    .previous_aux (previous_aux),
    .done_res     (done_res)
);

`default_nettype wire
